[rtl/cfse_pkg.sv]
// Shared types, constants and tone tables for the cassette FSK sample encoder.
package cfse_pkg;

   localparam int LEADER_PERIOD   = 57;
   localparam int SYNC_PERIOD     = 17;
   localparam int ZERO_BIT_PERIOD = 22;
   localparam int ONE_BIT_PERIOD  = 44;

   localparam int TBL_DEPTH  = 64;
   localparam int WAVE_W     = 6;
   localparam int COUNT_W    = 16;
   localparam int BYTE_W     = 8;
   localparam int BITS_W     = 4;

   localparam logic [COUNT_W-1:0] LEADER_RESET = 16'd46746;
   localparam logic [BYTE_W-1:0]  CSUM_SEED    = 8'hFF;

   localparam real HALF_PI      = 1.5707963267948966;
   localparam real LEADER_STEP  = HALF_PI / LEADER_PERIOD;
   localparam real SYNC_STEP    = HALF_PI / SYNC_PERIOD;
   localparam real SYNC2_STEP   = HALF_PI / (2 * ZERO_BIT_PERIOD);
   localparam real ZERO_STEP    = HALF_PI / ZERO_BIT_PERIOD;
   localparam real ONE_STEP     = HALF_PI / ONE_BIT_PERIOD;

   typedef enum logic [1:0] {
      OP_START  = 2'd0,
      OP_LOAD   = 2'd1,
      OP_FINISH = 2'd2,
      OP_TICK   = 2'd3
   } op_type;

   typedef enum logic [5:0] {
      PH_IDLE   = 6'b000001,
      PH_LEADER = 6'b000010,
      PH_SYNC1  = 6'b000100,
      PH_SYNC2  = 6'b001000,
      PH_DATA   = 6'b010000,
      PH_DONE   = 6'b100000
   } phase_type;

   typedef struct packed {
      op_type             op;
      logic [BYTE_W-1:0]  data;
   } item_type;

   typedef struct packed {
      logic               finished;
      logic               accepted;
      logic               byte_wanted;
      logic               sample_valid;
      logic [BYTE_W-1:0]  sample;
   } rsp_type;

   typedef logic [BYTE_W-1:0] tbl_type [TBL_DEPTH];

   // trunc(127*sin(2*pi*n/d) + 127) by quarter-wave symmetry; step is (pi/2)/d
   function automatic logic [BYTE_W-1:0] tone_sample(int n, int d, real step);
      int nn;
      int q;
      int r;
      int u;
      int m;
      real s;
      nn = n;
      while (nn >= d) begin
         nn = nn - d;
      end
      q = 0;
      r = 4 * nn;
      while (r >= d) begin
         r = r - d;
         q = q + 1;
      end
      u = ((q % 2) == 1) ? d - r : r;
      if (u == 0) begin
         return 8'd127;
      end
      if (u == d) begin
         return (q < 2) ? 8'd254 : 8'd0;
      end
      s = 127.0 * $sin(step * u);
      m = int'($floor(s));
      if (m > 126) begin
         m = 126;
      end
      return (q < 2) ? 8'(127 + m) : 8'(126 - m);
   endfunction

   function automatic tbl_type build_table(int d, real step, int mul, int off, int count);
      tbl_type t;
      for (int k = 0; k < TBL_DEPTH; k++) begin
         t[k] = (k < count) ? tone_sample(mul * k + off, d, step) : '0;
      end
      return t;
   endfunction

   localparam tbl_type LEADER_TBL =
      build_table(LEADER_PERIOD, LEADER_STEP, 1, 0, LEADER_PERIOD);
   localparam tbl_type SYNC_TBL =
      build_table(SYNC_PERIOD, SYNC_STEP, 1, 0, SYNC_PERIOD / 2);
   localparam tbl_type SYNC2_TBL =
      build_table(2 * ZERO_BIT_PERIOD, SYNC2_STEP, 2, ZERO_BIT_PERIOD, ZERO_BIT_PERIOD / 2);
   localparam tbl_type ZERO_TBL =
      build_table(ZERO_BIT_PERIOD, ZERO_STEP, 1, 0, ZERO_BIT_PERIOD);
   localparam tbl_type ONE_TBL =
      build_table(ONE_BIT_PERIOD, ONE_STEP, 1, 0, ONE_BIT_PERIOD);

endpackage

[rtl/cfse_front.sv]
// Request intake: classifies each transaction and holds it in a two-entry queue.
module cfse_front (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_tvalid,
   output logic                     req_tready,
   input  logic [1:0]               req_tuser,
   input  logic [7:0]               req_tdata,
   output logic                     item_valid,
   output cfse_pkg::item_type       item,
   input  logic                     item_pop
);
   import cfse_pkg::*;

   item_type    slot_ff [2];
   logic        wr_ptr_ff;
   logic        wr_ptr_in;
   logic        rd_ptr_ff;
   logic        rd_ptr_in;
   logic [1:0]  count_ff;
   logic [1:0]  count_in;
   logic        push;
   logic        pop;
   item_type    new_item;

   assign req_tready = (count_ff != 2'd2);
   assign push       = req_tvalid && req_tready;
   assign item_valid = (count_ff != 2'd0);
   assign pop        = item_valid && item_pop;
   assign item       = slot_ff[rd_ptr_ff];

   always_comb begin
      new_item.op   = op_type'(req_tuser);
      new_item.data = req_tdata;
   end

   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 2'd1;
      end else if (pop && !push) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= new_item;
      end
   end

endmodule

[rtl/cfse_back.sv]
// Encoder engine: tone sequencing, byte holding, checksum and result register.
module cfse_back (
   input  logic                     clock,
   input  logic                     reset,
   input  logic [15:0]              leader_samples,
   input  logic                     item_valid,
   input  cfse_pkg::item_type       item,
   output logic                     item_pop,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output cfse_pkg::rsp_type        rsp
);
   import cfse_pkg::*;

   phase_type             phase_ff, phase_in;
   logic [COUNT_W-1:0]    count_ff, count_in;
   logic [WAVE_W-1:0]     wave_ff, wave_in;
   logic [BITS_W-1:0]     bits_ff, bits_in;
   logic [BYTE_W-1:0]     shift_ff, shift_in;
   logic [BYTE_W-1:0]     held_ff, held_in;
   logic                  held_valid_ff, held_valid_in;
   logic [BYTE_W-1:0]     csum_ff, csum_in;
   logic                  finish_ff, finish_in;
   rsp_type               rsp_ff, rsp_in;
   logic                  rsp_valid_ff, rsp_valid_in;

   logic                  take;
   logic                  armed;
   logic                  armed_next;
   logic [WAVE_W:0]       wave_inc;
   logic [COUNT_W-1:0]    count_inc;
   logic                  data_load;
   logic [BYTE_W-1:0]     shift_eff;
   logic [BITS_W-1:0]     bits_eff;
   logic [WAVE_W-1:0]     wave_eff;
   logic                  held_valid_eff;
   logic [WAVE_W:0]       wave_eff_inc;
   logic [WAVE_W:0]       bit_period;
   logic [BYTE_W-1:0]     bit_sample;
   logic [BITS_W-1:0]     bits_dec;

   assign take      = item_valid && (!rsp_valid_ff || rsp_ready);
   assign item_pop  = take;
   assign rsp_valid = rsp_valid_ff;
   assign rsp       = rsp_ff;

   assign armed     = (phase_ff != PH_IDLE) && (phase_ff != PH_DONE);
   assign wave_inc  = {1'b0, wave_ff} + 7'd1;
   assign count_inc = count_ff + 16'd1;

   assign data_load      = (bits_ff == '0) && held_valid_ff;
   assign shift_eff      = data_load ? held_ff : shift_ff;
   assign bits_eff       = data_load ? 4'd8 : bits_ff;
   assign wave_eff       = data_load ? '0 : wave_ff;
   assign held_valid_eff = data_load ? 1'b0 : held_valid_ff;
   assign wave_eff_inc   = {1'b0, wave_eff} + 7'd1;
   assign bit_period     = shift_eff[7] ? 7'(ONE_BIT_PERIOD) : 7'(ZERO_BIT_PERIOD);
   assign bit_sample     = shift_eff[7] ? ONE_TBL[wave_eff] : ZERO_TBL[wave_eff];
   assign bits_dec       = bits_eff - 4'd1;

   always_comb begin
      phase_in         = phase_ff;
      count_in         = count_ff;
      wave_in          = wave_ff;
      bits_in          = bits_ff;
      shift_in         = shift_ff;
      held_in          = held_ff;
      held_valid_in    = held_valid_ff;
      csum_in          = csum_ff;
      finish_in        = finish_ff;
      rsp_in           = '0;
      rsp_in.accepted  = 1'b1;
      case (item.op)
         OP_START: begin
            phase_in      = PH_LEADER;
            count_in      = '0;
            wave_in       = '0;
            bits_in       = '0;
            shift_in      = '0;
            held_in       = '0;
            held_valid_in = 1'b0;
            csum_in       = CSUM_SEED;
            finish_in     = 1'b0;
         end
         OP_LOAD, OP_FINISH: begin
            if (!armed || held_valid_ff || finish_ff) begin
               rsp_in.accepted = 1'b0;
            end else if (item.op == OP_LOAD) begin
               held_in       = item.data;
               held_valid_in = 1'b1;
               csum_in       = csum_ff ^ item.data;
            end else begin
               held_in       = csum_ff;
               held_valid_in = 1'b1;
               finish_in     = 1'b1;
            end
         end
         OP_TICK: begin
            case (phase_ff)
               PH_LEADER: begin
                  rsp_in.sample       = LEADER_TBL[wave_ff];
                  rsp_in.sample_valid = 1'b1;
                  wave_in  = (wave_inc == 7'(LEADER_PERIOD)) ? '0 : wave_inc[WAVE_W-1:0];
                  count_in = count_inc;
                  if (count_inc == leader_samples) begin
                     phase_in = PH_SYNC1;
                     wave_in  = '0;
                  end
               end
               PH_SYNC1: begin
                  rsp_in.sample       = SYNC_TBL[wave_ff];
                  rsp_in.sample_valid = 1'b1;
                  wave_in             = wave_inc[WAVE_W-1:0];
                  if (wave_inc >= 7'(SYNC_PERIOD / 2)) begin
                     phase_in = PH_SYNC2;
                     wave_in  = '0;
                  end
               end
               PH_SYNC2: begin
                  rsp_in.sample       = SYNC2_TBL[wave_ff];
                  rsp_in.sample_valid = 1'b1;
                  wave_in             = wave_inc[WAVE_W-1:0];
                  if (wave_inc >= 7'(ZERO_BIT_PERIOD / 2)) begin
                     phase_in = PH_DATA;
                     wave_in  = '0;
                     bits_in  = '0;
                  end
               end
               PH_DATA: begin
                  shift_in      = shift_eff;
                  bits_in       = bits_eff;
                  wave_in       = wave_eff;
                  held_valid_in = held_valid_eff;
                  if (bits_eff != '0) begin
                     rsp_in.sample       = bit_sample;
                     rsp_in.sample_valid = 1'b1;
                     wave_in             = wave_eff_inc[WAVE_W-1:0];
                     if (wave_eff_inc >= bit_period) begin
                        wave_in  = '0;
                        shift_in = {shift_eff[BYTE_W-2:0], 1'b0};
                        bits_in  = bits_dec;
                        if ((bits_dec == '0) && finish_ff && !held_valid_eff) begin
                           phase_in = PH_DONE;
                        end
                     end
                  end
               end
               default: begin
               end
            endcase
         end
         default: begin
         end
      endcase
      armed_next         = (phase_in != PH_IDLE) && (phase_in != PH_DONE);
      rsp_in.byte_wanted = armed_next && !held_valid_in && !finish_in;
      rsp_in.finished    = (phase_in == PH_DONE);
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (take) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= PH_IDLE;
         count_ff      <= '0;
         wave_ff       <= '0;
         bits_ff       <= '0;
         shift_ff      <= '0;
         held_ff       <= '0;
         held_valid_ff <= 1'b0;
         csum_ff       <= CSUM_SEED;
         finish_ff     <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (take) begin
            phase_ff      <= phase_in;
            count_ff      <= count_in;
            wave_ff       <= wave_in;
            bits_ff       <= bits_in;
            shift_ff      <= shift_in;
            held_ff       <= held_in;
            held_valid_ff <= held_valid_in;
            csum_ff       <= csum_in;
            finish_ff     <= finish_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         rsp_ff <= rsp_in;
      end
   end

endmodule

[rtl/cassette_fsk_sample_encoder_core.sv]
// Top level of the cassette FSK sample encoder: CSR, request queue and encoder engine.
//
//   port group   dir   payload
//   req_*        in    tuser = mode[1:0], tdata = data_byte[7:0]
//   rsp_*        out   tuser = sample_valid, tdata = sample, byte_wanted, accepted, finished
//   csr_*        in    wr_data = leader_samples[15:0]
//
// One transaction per cycle sustained while rsp_tready is held high; a request is written into
// a queue slot when accepted, then its result into the result register once the engine takes it.
// Reset is synchronous; the leader length returns to 46746 and the engine goes idle.
// While a result waits on rsp_tready the two-entry queue absorbs up to two more requests,
// then req_tready drops until the result is taken.
module cassette_fsk_sample_encoder_core (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [1:0]   req_tuser,   // mode[1:0]
   input  logic [7:0]   req_tdata,   // data_byte[7:0]
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [0:0]   rsp_tuser,   // sample_valid[0]
   output logic [15:0]  rsp_tdata,   // sample[7:0], byte_wanted[8], accepted[9],
                                     // finished[10], zero[15:11]
   input  logic         csr_wr_en,
   input  logic [15:0]  csr_wr_data
);
   import cfse_pkg::*;

   logic [COUNT_W-1:0]  leader_ff;
   logic [COUNT_W-1:0]  leader_in;
   logic                item_valid;
   item_type            item;
   logic                item_pop;
   rsp_type             rsp;

   assign leader_in = csr_wr_en ? csr_wr_data : leader_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         leader_ff <= LEADER_RESET;
      end else begin
         leader_ff <= leader_in;
      end
   end

   cfse_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tuser  (req_tuser),
      .req_tdata  (req_tdata),
      .item_valid (item_valid),
      .item       (item),
      .item_pop   (item_pop)
   );

   cfse_back u_back (
      .clock          (clock),
      .reset          (reset),
      .leader_samples (leader_ff),
      .item_valid     (item_valid),
      .item           (item),
      .item_pop       (item_pop),
      .rsp_valid      (rsp_tvalid),
      .rsp_ready      (rsp_tready),
      .rsp            (rsp)
   );

   assign rsp_tuser = rsp.sample_valid;
   assign rsp_tdata = {5'd0, rsp.finished, rsp.accepted, rsp.byte_wanted, rsp.sample};

endmodule
